### rtl/efr_pkg.sv
`default_nettype none

package efr_pkg;

  // Field widths of the 12.4 coordinate format and the colour channels
  localparam int COORD_W  = 16;
  localparam int SUB_BITS = 4;
  localparam int PIX_W    = COORD_W - SUB_BITS;
  localparam int COLOUR_W = 8;

  // Edge arithmetic: coefficient, product and edge-value widths
  localparam int STEP_W = COORD_W + 1;
  localparam int PROD_W = 2 * STEP_W;
  localparam int EDGE_W = PROD_W + 2;

  // Item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    logic                       is_step;
    logic signed [COORD_W-1:0]  vx0;
    logic signed [COORD_W-1:0]  vy0;
    logic signed [COORD_W-1:0]  vx1;
    logic signed [COORD_W-1:0]  vy1;
    logic signed [COORD_W-1:0]  vx2;
    logic signed [COORD_W-1:0]  vy2;
    logic signed [PIX_W-1:0]    box_x_start;
    logic signed [PIX_W-1:0]    box_x_end;
    logic signed [PIX_W-1:0]    box_y_start;
    logic signed [PIX_W-1:0]    box_y_end;
    logic                       box_nonempty;
    logic [COLOUR_W-1:0]        red;
    logic [COLOUR_W-1:0]        green;
    logic [COLOUR_W-1:0]        blue;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/efr_front.sv
`default_nettype none

module efr_front (
  input  wire logic                                 opcode,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   first_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   first_y,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   second_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   second_y,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   third_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   third_y,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_red,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_green,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_blue,
  output efr_pkg::cmd_t                             cmd
);

  function automatic logic signed [efr_pkg::COORD_W-1:0] min3(
    input logic signed [efr_pkg::COORD_W-1:0] a,
    input logic signed [efr_pkg::COORD_W-1:0] b,
    input logic signed [efr_pkg::COORD_W-1:0] c
  );
    logic signed [efr_pkg::COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [efr_pkg::COORD_W-1:0] max3(
    input logic signed [efr_pkg::COORD_W-1:0] a,
    input logic signed [efr_pkg::COORD_W-1:0] b,
    input logic signed [efr_pkg::COORD_W-1:0] c
  );
    logic signed [efr_pkg::COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Integer part rounded down: drop the fraction bits
  function automatic logic signed [efr_pkg::PIX_W-1:0] floor_int(
    input logic signed [efr_pkg::COORD_W-1:0] v
  );
    return v[efr_pkg::COORD_W-1:efr_pkg::SUB_BITS];
  endfunction

  // Integer part rounded toward zero: negative values with a fraction go up one
  function automatic logic signed [efr_pkg::PIX_W-1:0] trunc_int(
    input logic signed [efr_pkg::COORD_W-1:0] v
  );
    logic signed [efr_pkg::PIX_W-1:0] f;
    f = v[efr_pkg::COORD_W-1:efr_pkg::SUB_BITS];
    if (v[efr_pkg::COORD_W-1] && (v[efr_pkg::SUB_BITS-1:0] != '0)) begin
      f = f + efr_pkg::PIX_W'(1);
    end
    return f;
  endfunction

  logic signed [efr_pkg::COORD_W-1:0] min_x;
  logic signed [efr_pkg::COORD_W-1:0] max_x;
  logic signed [efr_pkg::COORD_W-1:0] min_y;
  logic signed [efr_pkg::COORD_W-1:0] max_y;
  logic signed [efr_pkg::PIX_W-1:0]   bx_start;
  logic signed [efr_pkg::PIX_W-1:0]   bx_end;
  logic signed [efr_pkg::PIX_W-1:0]   by_start;
  logic signed [efr_pkg::PIX_W-1:0]   by_end;

  // Bounding box does not depend on the winding, so work it out here
  always_comb begin
    min_x    = min3(first_x, second_x, third_x);
    max_x    = max3(first_x, second_x, third_x);
    min_y    = min3(first_y, second_y, third_y);
    max_y    = max3(first_y, second_y, third_y);
    bx_start = trunc_int(min_x);
    bx_end   = floor_int(max_x);
    by_start = trunc_int(min_y);
    by_end   = floor_int(max_y);
  end

  // Classify the item and pack it for the queue
  always_comb begin
    cmd              = '0;
    cmd.is_step      = (opcode == efr_pkg::OP_STEP);
    cmd.vx0          = first_x;
    cmd.vy0          = first_y;
    cmd.vx1          = second_x;
    cmd.vy1          = second_y;
    cmd.vx2          = third_x;
    cmd.vy2          = third_y;
    cmd.box_x_start  = bx_start;
    cmd.box_x_end    = bx_end;
    cmd.box_y_start  = by_start;
    cmd.box_y_end    = by_end;
    cmd.box_nonempty = (bx_start <= bx_end) && (by_start <= by_end);
    cmd.red          = fill_red;
    cmd.green        = fill_green;
    cmd.blue         = fill_blue;
  end

endmodule

`default_nettype wire

### rtl/efr_queue.sv
`default_nettype none

module efr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire efr_pkg::cmd_t  wdata,
  output logic                full,
  input  wire logic           pop,
  output efr_pkg::cmd_t       rdata,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  efr_pkg::cmd_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Store a transfer at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (push && full && !pop) |=> $stable(count))
    else $error("push into a full queue changed the fill count");

endmodule

`default_nettype wire

### rtl/efr_back.sv
`default_nettype none

module efr_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cmd_empty,
  input  wire efr_pkg::cmd_t                        cmd,
  output logic                                      cmd_pop,
  input  wire logic                                 pop,
  output logic                                      empty,
  output logic signed [efr_pkg::PIX_W-1:0]          pixel_x,
  output logic signed [efr_pkg::PIX_W-1:0]          pixel_y,
  output logic                                      covered,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_red,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_green,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_blue,
  output logic                                      last_pixel
);

  localparam int COORD_W = efr_pkg::COORD_W;
  localparam int SUB     = efr_pkg::SUB_BITS;
  localparam int PIX_W   = efr_pkg::PIX_W;
  localparam int STEP_W  = efr_pkg::STEP_W;
  localparam int PROD_W  = efr_pkg::PROD_W;
  localparam int EDGE_W  = efr_pkg::EDGE_W;

  // Back states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  // Load sequencer steps
  localparam logic [3:0] LD_CROSS_A = 4'd0;
  localparam logic [3:0] LD_CROSS_B = 4'd1;
  localparam logic [3:0] LD_SWAP    = 4'd2;
  localparam logic [3:0] LD_E0_X    = 4'd3;
  localparam logic [3:0] LD_E0_Y    = 4'd4;
  localparam logic [3:0] LD_E1_X    = 4'd5;
  localparam logic [3:0] LD_E1_Y    = 4'd6;
  localparam logic [3:0] LD_E2_X    = 4'd7;
  localparam logic [3:0] LD_E2_Y    = 4'd8;
  localparam logic [3:0] LD_DONE    = 4'd9;

  logic                       state;
  logic [3:0]                 ld_cnt;
  logic                       active;

  logic signed [COORD_W-1:0]  vx0, vy0, vx1, vy1, vx2, vy2;
  logic signed [PIX_W-1:0]    box_x_start, box_x_end, box_y_start, box_y_end;
  logic signed [PIX_W-1:0]    walk_x, walk_y;
  logic [efr_pkg::COLOUR_W-1:0] col_red, col_green, col_blue;

  logic signed [STEP_W-1:0]   sx [3];
  logic signed [STEP_W-1:0]   sy [3];
  logic signed [EDGE_W-1:0]   e_row [3];
  logic signed [EDGE_W-1:0]   e_col [3];

  logic signed [STEP_W-1:0]   sx_c [3];
  logic signed [STEP_W-1:0]   sy_c [3];
  logic signed [STEP_W-1:0]   ma;
  logic signed [STEP_W-1:0]   mb;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   acc;
  logic [PROD_W:0]            winding;
  logic [EDGE_W-1:0]          e_sum;
  logic signed [COORD_W-1:0]  px0;
  logic signed [COORD_W-1:0]  py0;

  logic                       out_valid;
  logic                       out_ready;
  logic                       res_fire;
  logic                       last_c;
  logic                       covered_c;

  function automatic logic signed [STEP_W-1:0] diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic logic signed [EDGE_W-1:0] scaled_step(
    input logic signed [STEP_W-1:0] s
  );
    return {{(EDGE_W - STEP_W - SUB){s[STEP_W-1]}}, s, {SUB{1'b0}}};
  endfunction

  // Edge coefficients from the held (possibly swapped) vertices
  always_comb begin
    sx_c[0] = diff(vy0, vy1);
    sy_c[0] = diff(vx1, vx0);
    sx_c[1] = diff(vy1, vy2);
    sy_c[1] = diff(vx2, vx1);
    sx_c[2] = diff(vy2, vy0);
    sy_c[2] = diff(vx0, vx2);
  end

  assign px0 = {box_x_start, {SUB{1'b0}}};
  assign py0 = {box_y_start, {SUB{1'b0}}};

  // Select operands for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_LOAD) begin
      unique case (ld_cnt)
        LD_CROSS_A: begin ma = diff(vx1, vx0); mb = diff(vy2, vy0); end
        LD_CROSS_B: begin ma = diff(vx2, vx0); mb = diff(vy1, vy0); end
        LD_E0_X:    begin ma = sx_c[0];        mb = diff(px0, vx0); end
        LD_E0_Y:    begin ma = sy_c[0];        mb = diff(py0, vy0); end
        LD_E1_X:    begin ma = sx_c[1];        mb = diff(px0, vx1); end
        LD_E1_Y:    begin ma = sy_c[1];        mb = diff(py0, vy1); end
        LD_E2_X:    begin ma = sx_c[2];        mb = diff(px0, vx2); end
        LD_E2_Y:    begin ma = sy_c[2];        mb = diff(py0, vy2); end
        default:    begin ma = '0;             mb = '0;             end
      endcase
    end
  end

  // Register each product before it is summed
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign winding = {acc[PROD_W-1], acc} - {prod[PROD_W-1], prod};
  assign e_sum = {{(EDGE_W - PROD_W){acc[PROD_W-1]}}, acc}
               + {{(EDGE_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Result of a step at the current pixel
  always_comb begin
    covered_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (e_row[i][EDGE_W-1]) begin
        covered_c = 1'b0;
      end
    end
  end

  assign last_c    = (walk_x == box_x_end) && (walk_y == box_y_end);
  assign out_ready = !out_valid || pop;
  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty
                   && (!cmd.is_step || !active || out_ready);
  assign res_fire  = cmd_pop && cmd.is_step && active;

  // Control: sequencer state and triangle activity
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ld_cnt <= LD_CROSS_A;
      active <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop && !cmd.is_step) begin
            active <= 1'b0;
            ld_cnt <= LD_CROSS_A;
            if (cmd.box_nonempty) begin
              state <= ST_LOAD;
            end
          end else if (res_fire && last_c) begin
            active <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (ld_cnt == LD_DONE) begin
            state  <= ST_IDLE;
            active <= 1'b1;
          end else begin
            ld_cnt <= ld_cnt + 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: latch the triangle, build edges, walk the box
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.is_step) begin
      vx0         <= cmd.vx0;
      vy0         <= cmd.vy0;
      vx1         <= cmd.vx1;
      vy1         <= cmd.vy1;
      vx2         <= cmd.vx2;
      vy2         <= cmd.vy2;
      box_x_start <= cmd.box_x_start;
      box_x_end   <= cmd.box_x_end;
      box_y_start <= cmd.box_y_start;
      box_y_end   <= cmd.box_y_end;
      walk_x      <= cmd.box_x_start;
      walk_y      <= cmd.box_y_start;
      col_red     <= cmd.red;
      col_green   <= cmd.green;
      col_blue    <= cmd.blue;
    end
    if (state == ST_LOAD) begin
      unique case (ld_cnt)
        LD_CROSS_B: acc <= prod;
        LD_SWAP: begin
          // Clockwise winding: swap the second and third vertices
          if (winding[PROD_W]) begin
            vx1 <= vx2;
            vy1 <= vy2;
            vx2 <= vx1;
            vy2 <= vy1;
          end
        end
        LD_E0_X: begin
          for (int i = 0; i < 3; i++) begin
            sx[i] <= sx_c[i];
            sy[i] <= sy_c[i];
          end
        end
        LD_E0_Y: acc <= prod;
        LD_E1_X: begin e_row[0] <= e_sum; e_col[0] <= e_sum; end
        LD_E1_Y: acc <= prod;
        LD_E2_X: begin e_row[1] <= e_sum; e_col[1] <= e_sum; end
        LD_E2_Y: acc <= prod;
        LD_DONE: begin e_row[2] <= e_sum; e_col[2] <= e_sum; end
        default: acc <= acc;
      endcase
    end
    if (res_fire && !last_c) begin
      if (walk_y < box_y_end) begin
        // Next row in the same column
        walk_y <= walk_y + PIX_W'(1);
        for (int i = 0; i < 3; i++) begin
          e_row[i] <= e_row[i] + scaled_step(sy[i]);
        end
      end else begin
        // Top of the next column
        walk_y <= box_y_start;
        walk_x <= walk_x + PIX_W'(1);
        for (int i = 0; i < 3; i++) begin
          e_col[i] <= e_col[i] + scaled_step(sx[i]);
          e_row[i] <= e_col[i] + scaled_step(sx[i]);
        end
      end
    end
  end

  // Output register: hold until transfer, reload on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      pixel_x    <= walk_x;
      pixel_y    <= walk_y;
      covered    <= covered_c;
      out_red    <= col_red;
      out_green  <= col_green;
      out_blue   <= col_blue;
      last_pixel <= last_c;
    end
  end

  assign empty = !out_valid;

  a_no_pop_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !cmd_pop)
    else $error("item taken while the load sequencer is busy");

  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    active |-> ((walk_x <= box_x_end) && (walk_y <= box_y_end)))
    else $error("traversal left the bounding box");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_fire && last_c) |=> !active)
    else $error("triangle still active after its last pixel");

endmodule

`default_nettype wire

### rtl/edge_function_triangle_raster_core.sv
// Step item: its result is registered when the back takes it; one pixel per cycle sustained while results are popped.
// Load item: occupies the back while the load sequencer runs (eight products through one shared
// 17x17 multiplier, plus a winding swap step); an empty-box load does not enter the sequencer.
// Input queue of QUEUE_DEPTH items and a one-entry result register part the two sides.
// Synchronous active-high reset empties the queue and result register and leaves no
// triangle loaded; edge and box storage is not cleared.
`default_nettype none

module edge_function_triangle_raster_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic                                 opcode,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   first_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   first_y,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   second_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   second_y,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   third_x,
  input  wire logic signed [efr_pkg::COORD_W-1:0]   third_y,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_red,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_green,
  input  wire logic        [efr_pkg::COLOUR_W-1:0]  fill_blue,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [efr_pkg::PIX_W-1:0]          pixel_x,
  output logic signed [efr_pkg::PIX_W-1:0]          pixel_y,
  output logic                                      covered,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_red,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_green,
  output logic        [efr_pkg::COLOUR_W-1:0]       out_blue,
  output logic                                      last_pixel
);

  efr_pkg::cmd_t  front_cmd;
  efr_pkg::cmd_t  queue_cmd;
  logic           queue_empty;
  logic           queue_pop;

  // Classify incoming items
  efr_front u_front (
    .opcode     (opcode),
    .first_x    (first_x),
    .first_y    (first_y),
    .second_x   (second_x),
    .second_y   (second_y),
    .third_x    (third_x),
    .third_y    (third_y),
    .fill_red   (fill_red),
    .fill_green (fill_green),
    .fill_blue  (fill_blue),
    .cmd        (front_cmd)
  );

  // Decouple front and back
  efr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (queue_pop),
    .rdata (queue_cmd),
    .empty (queue_empty)
  );

  // Build edges and walk the box
  efr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (queue_empty),
    .cmd        (queue_cmd),
    .cmd_pop    (queue_pop),
    .pop        (pop),
    .empty      (empty),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .covered    (covered),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire
